[rtl/sample_set_statistics_unit_defines.svh]
// ----------------------------------------------------------------------------
// Sample set statistics unit - assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_SET_STATISTICS_UNIT_DEFINES_SVH
`define SAMPLE_SET_STATISTICS_UNIT_DEFINES_SVH

// same-cycle implication
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// Sample set statistics unit - package
// Widths, reset values, register map and controller/datapath links.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_W        = 16;
    localparam int UNDER_W         = 11;
    localparam int ROOT_STEPS      = 16;
    localparam int CFG_AW          = 3;
    localparam int CFG_DW          = 32;

    localparam logic [SAMPLE_W-1:0] UNDER_THR_RST = 16'd5120;

    // register index, taken from paddr[CFG_AW-1]
    localparam logic REG_UNDER_THR = 1'b0;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_var;
        logic sq_issue;
        logic start_sqrt;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic sq_done;
        logic sqrt_busy;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/sss_if.sv]
// ----------------------------------------------------------------------------
// Sample set statistics unit - stream interfaces
// Sample input channel and statistics result channel, valid/ready beats.
// ----------------------------------------------------------------------------
interface sss_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface sss_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mean;
    logic [15:0] std_dev;
    logic [10:0] under_count;
    logic [15:0] max_weight;
    logic [15:0] lightest;
    logic        overflowed;
    modport source (output valid, output mean, output std_dev, output under_count,
                    output max_weight, output lightest, output overflowed,
                    input ready);
    modport sink   (input valid, input mean, input std_dev, input under_count,
                    input max_weight, input lightest, input overflowed,
                    output ready);
endinterface

[rtl/sss_ram.sv]
// ----------------------------------------------------------------------------
// Sample set statistics unit - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sss_datapath.sv]
// ----------------------------------------------------------------------------
// Sample set statistics unit - datapath
// Sample store, running statistics, bit-serial divider, squared-difference
// pass, digit-serial square root and the result register.
// ----------------------------------------------------------------------------
`include "sample_set_statistics_unit_defines.svh"

module sss_datapath #(
    parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sss_pkg::t_dp_cmd                   i_cmd,
    output sss_pkg::t_dp_sts                   o_sts,
    input  logic [sss_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic [sss_pkg::SAMPLE_W-1:0]       i_under_thr,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [sss_pkg::SAMPLE_W-1:0]       o_mean,
    output logic [sss_pkg::SAMPLE_W-1:0]       o_std_dev,
    output logic [sss_pkg::UNDER_W-1:0]        o_under_count,
    output logic [sss_pkg::SAMPLE_W-1:0]       o_max_weight,
    output logic [sss_pkg::SAMPLE_W-1:0]       o_lightest,
    output logic                               o_overflowed
);
    import sss_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int SW  = SAMPLE_W + CW;
    localparam int SQW = 2 * SAMPLE_W + CW;
    localparam int DCW = $clog2(SQW + 1);
    localparam int RCW = $clog2(ROOT_STEPS + 1);
    localparam int RW  = SAMPLE_W + 1;

    // set state
    logic [CW-1:0]       r_count;
    logic [SW-1:0]       r_sum;
    logic [SAMPLE_W-1:0] r_max;
    logic [SAMPLE_W-1:0] r_min;
    logic [UNDER_W-1:0]  r_below;
    logic [SQW-1:0]      r_sq;
    logic                r_ovf;

    // squared-difference pass
    logic [CW-1:0]         r_rd_idx;
    logic                  r_v1;
    logic                  r_v2;
    logic [2*SAMPLE_W-1:0] r_prod;
    logic [SAMPLE_W-1:0]   r_mean;

    // divider
    logic [SQW-1:0] r_quo;
    logic [CW-1:0]  r_rem;
    logic [DCW-1:0] r_div_cnt;

    // square root
    logic [2*SAMPLE_W-1:0] r_rad;
    logic [SAMPLE_W-1:0]   r_root;
    logic [RW-1:0]         r_srem;
    logic [RCW-1:0]        r_sqrt_cnt;

    // result register
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_o_mean;
    logic [SAMPLE_W-1:0] r_o_sd;
    logic [UNDER_W-1:0]  r_o_under;
    logic [SAMPLE_W-1:0] r_o_max;
    logic [SAMPLE_W-1:0] r_o_min;
    logic                r_o_ovf;

    logic                full;
    logic                wr;
    logic                issue;
    logic [SAMPLE_W-1:0] rdata;
    logic [SAMPLE_W-1:0] cur_mean;
    logic [SAMPLE_W-1:0] diff;
    logic [CW:0]         rem_sh;
    logic [CW:0]         cnt_ext;
    logic                div_ge;
    logic [CW:0]         rem_nx;
    logic [RW+1:0]       srem_sh;
    logic [RW+1:0]       trial;
    logic                sqrt_ge;
    logic [RW+1:0]       srem_nx;

    assign full  = (r_count == CW'(MAX_SAMPLES));
    assign wr    = i_cmd.load && !full;
    assign issue = i_cmd.sq_issue && (r_rd_idx < r_count);

    sss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign cur_mean = r_quo[SAMPLE_W-1:0];
    assign diff     = (rdata >= cur_mean) ? (rdata - cur_mean) : (cur_mean - rdata);

    assign cnt_ext = {1'b0, r_count};
    assign rem_sh  = {r_rem, r_quo[SQW-1]};
    assign div_ge  = (rem_sh >= cnt_ext);
    assign rem_nx  = div_ge ? (rem_sh - cnt_ext) : rem_sh;

    assign srem_sh = {r_srem, r_rad[2*SAMPLE_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign sqrt_ge = (srem_sh >= trial);
    assign srem_nx = sqrt_ge ? (srem_sh - trial) : srem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '1;
            r_below     <= '0;
            r_sq        <= '0;
            r_ovf       <= 1'b0;
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_div_cnt   <= '0;
            r_sqrt_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load
            if (wr) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SW'(i_sample);
                if (i_sample > r_max) begin
                    r_max <= i_sample;
                end
                if (i_sample < r_min) begin
                    r_min <= i_sample;
                end
                if (i_sample < i_under_thr) begin
                    r_below <= r_below + 1'b1;
                end
            end else if (i_cmd.load) begin
                r_ovf <= 1'b1;
            end

            // squared-difference pass
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_v2) begin
                r_sq <= r_sq + SQW'(r_prod);
            end

            // divider
            if (i_cmd.start_div) begin
                r_div_cnt <= DCW'(SQW);
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end

            // square root
            if (i_cmd.start_sqrt) begin
                r_sqrt_cnt <= RCW'(ROOT_STEPS);
            end else if (r_sqrt_cnt != '0) begin
                r_sqrt_cnt <= r_sqrt_cnt - 1'b1;
            end

            // result beat
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.finish) begin
                r_count  <= '0;
                r_sum    <= '0;
                r_max    <= '0;
                r_min    <= '1;
                r_below  <= '0;
                r_sq     <= '0;
                r_ovf    <= 1'b0;
                r_rd_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= diff * diff;
        end

        if (i_cmd.start_div) begin
            r_quo <= i_cmd.div_var ? r_sq : SQW'(r_sum);
            r_rem <= '0;
            if (i_cmd.div_var) begin
                r_mean <= cur_mean;
            end
        end else if (r_div_cnt != '0) begin
            r_quo <= {r_quo[SQW-2:0], div_ge};
            r_rem <= rem_nx[CW-1:0];
        end

        if (i_cmd.start_sqrt) begin
            r_rad  <= r_quo[2*SAMPLE_W-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (r_sqrt_cnt != '0) begin
            r_rad  <= {r_rad[2*SAMPLE_W-3:0], 2'b00};
            r_root <= {r_root[SAMPLE_W-2:0], sqrt_ge};
            r_srem <= srem_nx[RW-1:0];
        end

        if (i_cmd.finish) begin
            r_o_mean  <= r_mean;
            r_o_sd    <= r_root;
            r_o_under <= r_below;
            r_o_max   <= r_max;
            r_o_min   <= r_min;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_sts.div_busy  = (r_div_cnt != '0);
    assign o_sts.sq_done   = (r_rd_idx == r_count) && !r_v1 && !r_v2;
    assign o_sts.sqrt_busy = (r_sqrt_cnt != '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_mean        = r_o_mean;
    assign o_std_dev     = r_o_sd;
    assign o_under_count = r_o_under;
    assign o_max_weight  = r_o_max;
    assign o_lightest    = r_o_min;
    assign o_overflowed  = r_o_ovf;

    `SSS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_SAMPLES), "sample count past capacity")
    `SSS_ASSERT_NOW(a_min_le_max, r_count != '0, r_min <= r_max, "running min above max")
    `SSS_ASSERT_NOW(a_ovf_full, r_ovf, full, "overflow flagged with store not full")
    `SSS_ASSERT_NEXT(a_set_clear, i_cmd.finish, r_count == '0 && r_sq == '0 && !r_ovf,
                     "set state not cleared after result")
endmodule

[rtl/sss_ctrl.sv]
// ----------------------------------------------------------------------------
// Sample set statistics unit - controller
// Sequences load, mean divide, squared-difference pass, variance divide,
// square root and the result beat.
// ----------------------------------------------------------------------------
module sss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  sss_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output sss_pkg::t_dp_cmd o_cmd
);
    import sss_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MEAN,
        ST_SQ,
        ST_VAR,
        ST_ROOT,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_start_div;
    logic   r_div_var;
    logic   r_start_sqrt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_start_div  <= 1'b0;
            r_div_var    <= 1'b0;
            r_start_sqrt <= 1'b0;
        end else begin
            r_start_div  <= 1'b0;
            r_start_sqrt <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (i_in_valid && i_in_last) begin
                        r_state     <= ST_MEAN;
                        r_start_div <= 1'b1;
                        r_div_var   <= 1'b0;
                    end
                end
                ST_MEAN: begin
                    if (!r_start_div && !i_sts.div_busy) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (i_sts.sq_done) begin
                        r_state     <= ST_VAR;
                        r_start_div <= 1'b1;
                        r_div_var   <= 1'b1;
                    end
                end
                ST_VAR: begin
                    if (!r_start_div && !i_sts.div_busy) begin
                        r_state      <= ST_ROOT;
                        r_start_sqrt <= 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (!r_start_sqrt && !i_sts.sqrt_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_in_ready       = (r_state == ST_LOAD);
    assign o_cmd.load       = o_in_ready && i_in_valid;
    assign o_cmd.start_div  = r_start_div;
    assign o_cmd.div_var    = r_div_var;
    assign o_cmd.sq_issue   = (r_state == ST_SQ);
    assign o_cmd.start_sqrt = r_start_sqrt;
    assign o_cmd.finish     = (r_state == ST_DONE) && i_sts.out_free;
endmodule

[rtl/sample_set_statistics_unit.sv]
// ----------------------------------------------------------------------------
// Sample set statistics unit - top level
// Mean, population standard deviation, min, max and underweight count of a
// set of unsigned Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage: samples arrive as beats on i_in, one per cycle while ready is high;
// a beat with last set closes the set. Up to MAX_SAMPLES are stored, later
// ones are dropped and reported in overflowed. One result beat per set
// leaves on o_out. The underweight threshold is written over the APB port at
// address 0 (reset 20.0); the user must change it only between sets, as the
// block itself does not enforce this.
// A set runs through load, mean divide, squared-difference pass, variance
// divide and square root, then into the result register. Both divides are
// bit-serial over SQW = 32 + clog2(MAX_SAMPLES+1) bits, and the pass reads
// the store through its single read port.
// The result sits in an output register: a stalled receiver holds the next
// set only at its final step, loading proceeds meanwhile. Reset clears all
// set state and the output valid; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module sample_set_statistics_unit #(
    parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sss_in_if.sink                      i_in,
    sss_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sss_pkg::CFG_AW-1:0]  paddr,
    input  logic [sss_pkg::CFG_DW-1:0]  pwdata,
    output logic [sss_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import sss_pkg::*;

    logic [SAMPLE_W-1:0] r_under_thr;
    logic                cfg_wr;
    t_dp_cmd             cmd;
    t_dp_sts             sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_UNDER_THR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_under_thr <= UNDER_THR_RST;
        end else if (cfg_wr) begin
            r_under_thr <= pwdata[SAMPLE_W-1:0];
        end
    end

    assign prdata = (paddr[CFG_AW-1] == REG_UNDER_THR) ?
                    {{(CFG_DW-SAMPLE_W){1'b0}}, r_under_thr} : '0;

    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    sss_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_sample      (i_in.sample),
        .i_under_thr   (r_under_thr),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_mean        (o_out.mean),
        .o_std_dev     (o_out.std_dev),
        .o_under_count (o_out.under_count),
        .o_max_weight  (o_out.max_weight),
        .o_lightest    (o_out.lightest),
        .o_overflowed  (o_out.overflowed)
    );
endmodule
